// ----- sv/quoted_string_unescaper_core_macros.svh -----
// assertion macros used by the checker file of the unescaper
`ifndef QUOTED_STRING_UNESCAPER_CORE_MACROS_SVH
`define QUOTED_STRING_UNESCAPER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define QSU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("unescaper check failed");

// next-cycle implication, checked outside reset
`define QSU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("unescaper check failed");

`endif

// ----- sv/qsu_pkg.sv -----
// types, codes and a helper function of the quoted string unescaper
`default_nettype none

package qsu_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX
    } phase_t;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_CHAR     = 3'd0;
    localparam kind_t KIND_DONE     = 3'd1;
    localparam kind_t KIND_NO_QUOTE = 3'd2;
    localparam kind_t KIND_TRUNC    = 3'd3;
    localparam kind_t KIND_BAD_HEX  = 3'd4;

    localparam logic [15:0] CH_SQUOTE = 16'h0027;
    localparam logic [15:0] CH_DQUOTE = 16'h0022;
    localparam logic [15:0] CH_BSLASH = 16'h005C;
    localparam logic [15:0] CH_N      = 16'h006E;
    localparam logic [15:0] CH_B      = 16'h0062;
    localparam logic [15:0] CH_F      = 16'h0066;
    localparam logic [15:0] CH_R      = 16'h0072;
    localparam logic [15:0] CH_T      = 16'h0074;
    localparam logic [15:0] CH_U      = 16'h0075;

    localparam logic [15:0] CC_LF = 16'h000A;
    localparam logic [15:0] CC_BS = 16'h0008;
    localparam logic [15:0] CC_FF = 16'h000C;
    localparam logic [15:0] CC_CR = 16'h000D;
    localparam logic [15:0] CC_HT = 16'h0009;

    localparam logic [1:0] HEX_LAST = 2'd3;

    typedef struct packed {
        logic [15:0] char_code;
        logic        end_of_data;
    } item_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [15:0] out_char;
    } result_t;

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] hex_digit(input logic [15:0] c);
        logic [15:0] d;
        logic [4:0]  r;
        d = 16'h0000;
        r = 5'b00000;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            d = c - 16'h0030;
            r = {1'b1, d[3:0]};
        end else if (c >= 16'h0061 && c <= 16'h0066) begin
            d = c - 16'h0057;
            r = {1'b1, d[3:0]};
        end else if (c >= 16'h0041 && c <= 16'h0046) begin
            d = c - 16'h0037;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/qsu_in_stage.sv -----
// input register of the unescaper
`default_nettype none

module qsu_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire qsu_pkg::item_t s_item,
    input  wire logic          take,
    output logic               item_valid,
    output qsu_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    qsu_pkg::item_t item_reg;

    // room when empty or when the held item leaves this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- sv/qsu_decoder.sv -----
// parser state machine: one character per step, at most one result
`default_nettype none

module qsu_decoder (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire qsu_pkg::item_t  item,
    output qsu_pkg::result_t     result
);

    qsu_pkg::phase_t phase_reg, phase_next;
    logic            quote_dbl_reg, quote_dbl_next;
    logic [1:0]      hex_cnt_reg, hex_cnt_next;
    logic [15:0]     hex_val_reg, hex_val_next;

    logic [15:0] c;
    logic        eod;
    logic [15:0] quote;
    logic [4:0]  hex_dig;
    logic [15:0] hex_acc;

    assign c       = item.char_code;
    assign eod     = item.end_of_data;
    assign quote   = quote_dbl_reg ? qsu_pkg::CH_DQUOTE : qsu_pkg::CH_SQUOTE;
    assign hex_dig = qsu_pkg::hex_digit(c);
    assign hex_acc = {hex_val_reg[11:0], hex_dig[3:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= qsu_pkg::PH_IDLE;
            quote_dbl_reg <= 1'b0;
            hex_cnt_reg   <= 2'd0;
            hex_val_reg   <= 16'h0000;
        end else begin
            phase_reg     <= phase_next;
            quote_dbl_reg <= quote_dbl_next;
            hex_cnt_reg   <= hex_cnt_next;
            hex_val_reg   <= hex_val_next;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        quote_dbl_next  = quote_dbl_reg;
        hex_cnt_next    = hex_cnt_reg;
        hex_val_next    = hex_val_reg;
        result.valid    = 1'b0;
        result.kind     = qsu_pkg::KIND_CHAR;
        result.out_char = 16'h0000;

        if (step) begin
            unique case (phase_reg)
                qsu_pkg::PH_IDLE: begin
                    if (!eod) begin
                        if (c == qsu_pkg::CH_SQUOTE || c == qsu_pkg::CH_DQUOTE) begin
                            quote_dbl_next = (c == qsu_pkg::CH_DQUOTE);
                            phase_next     = qsu_pkg::PH_BODY;
                        end else begin
                            result.valid = 1'b1;
                            result.kind  = qsu_pkg::KIND_NO_QUOTE;
                        end
                    end
                end
                qsu_pkg::PH_BODY: begin
                    if (eod) begin
                        result.valid = 1'b1;
                        result.kind  = qsu_pkg::KIND_TRUNC;
                    end else if (c == quote) begin
                        result.valid = 1'b1;
                        result.kind  = qsu_pkg::KIND_DONE;
                    end else if (c == qsu_pkg::CH_BSLASH) begin
                        phase_next = qsu_pkg::PH_ESC;
                    end else begin
                        result.valid    = 1'b1;
                        result.out_char = c;
                    end
                end
                qsu_pkg::PH_ESC: begin
                    if (eod) begin
                        result.valid = 1'b1;
                        result.kind  = qsu_pkg::KIND_TRUNC;
                    end else if (c == qsu_pkg::CH_U) begin
                        phase_next   = qsu_pkg::PH_HEX;
                        hex_cnt_next = 2'd0;
                        hex_val_next = 16'h0000;
                    end else begin
                        phase_next   = qsu_pkg::PH_BODY;
                        result.valid = 1'b1;
                        // unknown escapes pass the escaped character through
                        case (c)
                            qsu_pkg::CH_N: result.out_char = qsu_pkg::CC_LF;
                            qsu_pkg::CH_B: result.out_char = qsu_pkg::CC_BS;
                            qsu_pkg::CH_F: result.out_char = qsu_pkg::CC_FF;
                            qsu_pkg::CH_R: result.out_char = qsu_pkg::CC_CR;
                            qsu_pkg::CH_T: result.out_char = qsu_pkg::CC_HT;
                            default:       result.out_char = c;
                        endcase
                    end
                end
                qsu_pkg::PH_HEX: begin
                    if (eod) begin
                        result.valid = 1'b1;
                        result.kind  = qsu_pkg::KIND_TRUNC;
                    end else if (!hex_dig[4]) begin
                        result.valid = 1'b1;
                        result.kind  = qsu_pkg::KIND_BAD_HEX;
                    end else if (hex_cnt_reg == qsu_pkg::HEX_LAST) begin
                        phase_next      = qsu_pkg::PH_BODY;
                        hex_cnt_next    = 2'd0;
                        hex_val_next    = 16'h0000;
                        result.valid    = 1'b1;
                        result.out_char = hex_acc;
                    end else begin
                        hex_val_next = hex_acc;
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                end
            endcase

            // any terminating result drops back to idle
            if (result.valid && result.kind != qsu_pkg::KIND_CHAR) begin
                phase_next   = qsu_pkg::PH_IDLE;
                hex_cnt_next = 2'd0;
                hex_val_next = 16'h0000;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/qsu_out_stage.sv -----
// result register of the unescaper
`default_nettype none

module qsu_out_stage (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire qsu_pkg::result_t result,
    output logic                  free,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_result_kind,
    output logic [15:0]           m_out_char,
    output logic                  m_is_last
);

    logic        valid_reg, valid_next;
    logic [2:0]  kind_reg;
    logic [15:0] char_reg;
    logic        last_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (step) begin
            valid_next = result.valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && result.valid) begin
            kind_reg <= result.kind;
            char_reg <= result.out_char;
            last_reg <= (result.kind != qsu_pkg::KIND_CHAR);
        end
    end

    assign m_valid       = valid_reg;
    assign m_result_kind = kind_reg;
    assign m_out_char    = char_reg;
    assign m_is_last     = last_reg;

endmodule

`default_nettype wire

// ----- sv/quoted_string_unescaper_core.sv -----
// Quoted string unescaper, top level.
// Input channel (s_): one UTF-16 code unit per transfer on s_char_code, or
// s_end_of_data high when the text has run out. The first character must be
// a single or double quote; the same quote closes the string.
// Result channel (m_): zero or one result per input transfer. m_result_kind
// is 0 for a decoded character on m_out_char, 1 for string done, 2 for a
// missing opening quote, 3 for truncated text, 4 for a bad hex digit in a
// \u escape; m_is_last marks every kind but 0, after which the parser is idle.
// A result passes two registers: the transfer loads the input register, and
// the decode writes the result register once that register is free.
// Throughput: one input transfer per cycle while the receiver takes results;
// the decode is a state update between the two registers.
// When the receiver stalls, the held result stays put and the input register
// still takes one more item; s_ready then drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers and returns the
// parser to idle awaiting an opening quote.
`default_nettype none

module quoted_string_unescaper_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_char_code,
    input  wire logic        s_end_of_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_result_kind,
    output logic [15:0]      m_out_char,
    output logic             m_is_last
);

    qsu_pkg::item_t   s_item;
    qsu_pkg::item_t   item;
    qsu_pkg::result_t result;
    logic             item_valid;
    logic             out_free;
    logic             take;

    assign s_item.char_code   = s_char_code;
    assign s_item.end_of_data = s_end_of_data;

    // decode when an item is held and the result register can take its result
    assign take = item_valid && out_free;

    qsu_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    qsu_decoder u_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (take),
        .item    (item),
        .result  (result)
    );

    qsu_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (take),
        .result        (result),
        .free          (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_out_char    (m_out_char),
        .m_is_last     (m_is_last)
    );

endmodule

`default_nettype wire

// ----- sv/qsu_checker.sv -----
// port-level checks of the unescaper and their bind
`default_nettype none
`include "quoted_string_unescaper_core_macros.svh"

module qsu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [2:0]  m_result_kind,
    input wire logic [15:0] m_out_char,
    input wire logic        m_is_last
);

    `QSU_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_result_kind) && $stable(m_out_char) && $stable(m_is_last))
    `QSU_ASSERT_NOW(a_char_not_last, aclk, aresetn, m_valid && m_result_kind == qsu_pkg::KIND_CHAR, !m_is_last)
    `QSU_ASSERT_NOW(a_end_clean, aclk, aresetn, m_valid && m_result_kind != qsu_pkg::KIND_CHAR, m_is_last && m_out_char == 16'h0000)
    `QSU_ASSERT_NOW(a_kind_range, aclk, aresetn, m_valid, m_result_kind <= qsu_pkg::KIND_BAD_HEX)
    `QSU_ASSERT_NEXT(a_no_deadlock, aclk, aresetn, s_valid && !s_ready && m_ready, s_ready)

endmodule

bind quoted_string_unescaper_core qsu_checker u_qsu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_kind (m_result_kind),
    .m_out_char    (m_out_char),
    .m_is_last     (m_is_last)
);

`default_nettype wire

// ----- tb/tb_quoted_string_unescaper_core.sv -----
// testbench for the quoted string unescaper core
`timescale 1ns / 1ps

module tb_quoted_string_unescaper_core;

    localparam int CLK_HALF      = 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct {
        qsu_pkg::kind_t kind;
        logic [15:0]    ch;
        logic           last;
    } decoded_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic [15:0] s_char_code   = 16'h0000;
    logic        s_end_of_data = 1'b0;
    logic        m_ready       = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [2:0]  m_result_kind;
    logic [15:0] m_out_char;
    logic        m_is_last;

    // decoder shadow state
    qsu_pkg::phase_t dec_phase   = qsu_pkg::PH_IDLE;
    logic            dec_dq      = 1'b0;
    logic [1:0]      dec_hex_cnt = 2'd0;
    logic [15:0]     dec_hex_acc = 16'h0000;

    decoded_t    expected_q[$];
    int          fail_count      = 0;
    int          items_sent      = 0;
    int          strings_sent    = 0;
    int          results_checked = 0;
    int          cycle_count     = 0;
    int          sink_wait       = 0;
    bit          src_gap_en      = 1'b1;
    bit          sink_stall_en   = 1'b1;

    quoted_string_unescaper_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_code   (s_char_code),
        .s_end_of_data (s_end_of_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_out_char    (m_out_char),
        .m_is_last     (m_is_last)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // bit 4 set for a hex digit; 'a'/'A' have low nibble 1, so add 9
    function automatic logic [4:0] nibble_of(input logic [15:0] c);
        if (c >= 16'h0030 && c <= 16'h0039)
            return {1'b1, c[3:0]};
        if ((c >= 16'h0061 && c <= 16'h0066) || (c >= 16'h0041 && c <= 16'h0046))
            return {1'b1, c[3:0] + 4'd9};
        return 5'b00000;
    endfunction

    function automatic void push_result(input qsu_pkg::kind_t kind, input logic [15:0] ch);
        decoded_t r;
        r.kind = kind;
        r.ch   = (kind == qsu_pkg::KIND_CHAR) ? ch : 16'h0000;
        r.last = (kind != qsu_pkg::KIND_CHAR);
        expected_q.push_back(r);
        if (kind != qsu_pkg::KIND_CHAR) begin
            dec_phase   = qsu_pkg::PH_IDLE;
            dec_hex_cnt = 2'd0;
            dec_hex_acc = 16'h0000;
        end
    endfunction

    function automatic void decode_char(input logic [15:0] c, input logic eod);
        logic [15:0] quote;
        logic [15:0] mapped;
        logic [4:0]  nib;
        case (dec_phase)
            qsu_pkg::PH_IDLE: begin
                if (!eod) begin
                    if (c == qsu_pkg::CH_SQUOTE || c == qsu_pkg::CH_DQUOTE) begin
                        dec_dq    = (c == qsu_pkg::CH_DQUOTE);
                        dec_phase = qsu_pkg::PH_BODY;
                    end else begin
                        push_result(qsu_pkg::KIND_NO_QUOTE, 16'h0000);
                    end
                end
            end
            qsu_pkg::PH_BODY: begin
                quote = dec_dq ? qsu_pkg::CH_DQUOTE : qsu_pkg::CH_SQUOTE;
                if (eod)
                    push_result(qsu_pkg::KIND_TRUNC, 16'h0000);
                else if (c == quote)
                    push_result(qsu_pkg::KIND_DONE, 16'h0000);
                else if (c == qsu_pkg::CH_BSLASH)
                    dec_phase = qsu_pkg::PH_ESC;
                else
                    push_result(qsu_pkg::KIND_CHAR, c);
            end
            qsu_pkg::PH_ESC: begin
                if (eod) begin
                    push_result(qsu_pkg::KIND_TRUNC, 16'h0000);
                end else if (c == qsu_pkg::CH_U) begin
                    dec_phase   = qsu_pkg::PH_HEX;
                    dec_hex_cnt = 2'd0;
                    dec_hex_acc = 16'h0000;
                end else begin
                    dec_phase = qsu_pkg::PH_BODY;
                    case (c)
                        qsu_pkg::CH_N: mapped = qsu_pkg::CC_LF;
                        qsu_pkg::CH_B: mapped = qsu_pkg::CC_BS;
                        qsu_pkg::CH_F: mapped = qsu_pkg::CC_FF;
                        qsu_pkg::CH_R: mapped = qsu_pkg::CC_CR;
                        qsu_pkg::CH_T: mapped = qsu_pkg::CC_HT;
                        default:       mapped = c;
                    endcase
                    push_result(qsu_pkg::KIND_CHAR, mapped);
                end
            end
            default: begin
                nib = nibble_of(c);
                if (eod) begin
                    push_result(qsu_pkg::KIND_TRUNC, 16'h0000);
                end else if (!nib[4]) begin
                    push_result(qsu_pkg::KIND_BAD_HEX, 16'h0000);
                end else begin
                    dec_hex_acc = {dec_hex_acc[11:0], nib[3:0]};
                    if (dec_hex_cnt == qsu_pkg::HEX_LAST) begin
                        mapped      = dec_hex_acc;
                        dec_phase   = qsu_pkg::PH_BODY;
                        dec_hex_cnt = 2'd0;
                        dec_hex_acc = 16'h0000;
                        push_result(qsu_pkg::KIND_CHAR, mapped);
                    end else begin
                        dec_hex_cnt = dec_hex_cnt + 2'd1;
                    end
                end
            end
        endcase
    endfunction

    // one input transfer; valid stays up across back-to-back items
    task automatic send_char(input logic [15:0] c, input logic eod);
        int gap;
        gap = src_gap_en ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_char_code   <= c;
        s_end_of_data <= eod;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!(eod && dec_phase == qsu_pkg::PH_IDLE))
            items_sent++;
        decode_char(c, eod);
    endtask

    task automatic send_eod();
        send_char(16'($urandom_range(0, 65535)), 1'b1);
    endtask

    task automatic check_result();
        decoded_t want;
        results_checked++;
        if (expected_q.size() == 0) begin
            $error("unexpected result: kind %0d char %h last %0b",
                   m_result_kind, m_out_char, m_is_last);
            fail_count++;
        end else begin
            want = expected_q.pop_front();
            if (m_result_kind !== want.kind) begin
                $error("result_kind mismatch: expected %0d, actual %0d",
                       want.kind, m_result_kind);
                fail_count++;
            end
            if (m_out_char !== want.ch) begin
                $error("out_char mismatch: expected %h, actual %h", want.ch, m_out_char);
                fail_count++;
            end
            if (m_is_last !== want.last) begin
                $error("is_last mismatch: expected %0b, actual %0b", want.last, m_is_last);
                fail_count++;
            end
        end
    endtask

    // result side: check each transfer, then stall a random number of cycles when stalls are enabled
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result();
                sink_wait = sink_stall_en ? $urandom_range(0, 5) : 0;
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_ready <= (sink_wait == 0);
        end
    end

    function automatic logic [15:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 16'h0030 + 16'(nib);
        return (upper ? 16'h0041 : 16'h0061) + 16'(nib - 4'd10);
    endfunction

    function automatic logic [15:0] rand_hex_char();
        return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic logic [15:0] rand_non_hex_char();
        logic [15:0] near_hex[9];
        logic [15:0] c;
        // characters right next to the digit ranges, plus space, minus and plus signs
        near_hex = '{16'h002F, 16'h003A, 16'h0040, 16'h0047, 16'h0060,
                     16'h0067, 16'h0020, 16'h002D, 16'h002B};
        if ($urandom_range(0, 1))
            return near_hex[$urandom_range(0, 8)];
        c = 16'($urandom_range(0, 65535));
        while (nibble_of(c) != 5'b00000)
            c = 16'($urandom_range(0, 65535));
        return c;
    endfunction

    function automatic logic [15:0] rand_body_char(input logic [15:0] quote);
        logic [15:0] c;
        if ($urandom_range(0, 9) == 0)
            return (quote == qsu_pkg::CH_DQUOTE) ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
        if ($urandom_range(0, 1))
            c = 16'($urandom_range(16'h0020, 16'h007E));
        else
            c = 16'($urandom_range(0, 65535));
        if (c == quote || c == qsu_pkg::CH_BSLASH)
            c = 16'h0041;
        return c;
    endfunction

    function automatic logic [15:0] rand_escaped_char();
        logic [15:0] simple[5];
        logic [15:0] c;
        simple = '{qsu_pkg::CH_N, qsu_pkg::CH_B, qsu_pkg::CH_F, qsu_pkg::CH_R, qsu_pkg::CH_T};
        case ($urandom_range(0, 3))
            0, 1: c = simple[$urandom_range(0, 4)];
            2: begin
                case ($urandom_range(0, 2))
                    0:       c = qsu_pkg::CH_SQUOTE;
                    1:       c = qsu_pkg::CH_DQUOTE;
                    default: c = qsu_pkg::CH_BSLASH;
                endcase
            end
            default: c = 16'($urandom_range(0, 65535));
        endcase
        if (c == qsu_pkg::CH_U)
            c = qsu_pkg::CH_BSLASH;
        return c;
    endfunction

    task automatic send_unicode_escape(input int digits);
        send_char(qsu_pkg::CH_BSLASH, 1'b0);
        send_char(qsu_pkg::CH_U, 1'b0);
        repeat (digits) send_char(rand_hex_char(), 1'b0);
    endtask

    // mostly complete strings; some cut short, some with a bad digit, some unquoted or bare end of data
    task automatic send_random_string();
        logic [15:0] quote;
        logic [15:0] c;
        int          roll;
        int          len;
        int          cut_at;
        int          stage;
        bit          broken;
        bit          bad_hex;
        roll = $urandom_range(0, 99);
        strings_sent++;
        if (roll < 4) begin
            send_eod();
            return;
        end
        if (roll < 10) begin
            c = 16'($urandom_range(0, 65535));
            if (c == qsu_pkg::CH_SQUOTE || c == qsu_pkg::CH_DQUOTE)
                c = 16'h0030;
            send_char(c, 1'b0);
            return;
        end
        broken  = (roll < 28);
        bad_hex = 1'($urandom_range(0, 1));
        quote   = $urandom_range(0, 1) ? qsu_pkg::CH_DQUOTE : qsu_pkg::CH_SQUOTE;
        len     = $urandom_range(0, 10);
        cut_at  = $urandom_range(0, len);
        send_char(quote, 1'b0);
        for (int i = 0; i <= len; i++) begin
            if (broken && i == cut_at) begin
                if (bad_hex) begin
                    send_unicode_escape($urandom_range(0, 3));
                    send_char(rand_non_hex_char(), 1'b0);
                end else begin
                    stage = $urandom_range(0, 5);
                    if (stage == 1)
                        send_char(qsu_pkg::CH_BSLASH, 1'b0);
                    else if (stage >= 2)
                        send_unicode_escape(stage - 2);
                    send_eod();
                end
                return;
            end
            if (i == len)
                break;
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                send_char(rand_body_char(quote), 1'b0);
            end else if (roll < 8) begin
                send_char(qsu_pkg::CH_BSLASH, 1'b0);
                send_char(rand_escaped_char(), 1'b0);
            end else begin
                send_unicode_escape(4);
            end
        end
        send_char(quote, 1'b0);
    endtask

    task automatic test_framing();
        send_eod();                                // end of data while idle: ignored
        send_char(16'hFFFF, 1'b0);                 // not a quote
        send_char(qsu_pkg::CH_SQUOTE, 1'b0);
        send_char(16'h0000, 1'b0);
        send_char(qsu_pkg::CH_DQUOTE, 1'b0);       // other quote is plain text
        send_char(16'hFFFF, 1'b0);
        send_char(qsu_pkg::CH_BSLASH, 1'b0);
        send_char(qsu_pkg::CH_SQUOTE, 1'b0);       // escaped quote does not close
        send_char(qsu_pkg::CH_SQUOTE, 1'b0);
    endtask

    task automatic test_escapes();
        send_char(qsu_pkg::CH_DQUOTE, 1'b0);
        send_char(qsu_pkg::CH_BSLASH, 1'b0);
        send_char(qsu_pkg::CH_N, 1'b0);
        send_char(qsu_pkg::CH_BSLASH, 1'b0);
        send_char(qsu_pkg::CH_U, 1'b0);
        send_char(hex_char(4'hA, 1'b0), 1'b0);
        send_char(hex_char(4'hF, 1'b1), 1'b0);
        send_char(hex_char(4'h0, 1'b0), 1'b0);
        send_char(hex_char(4'h9, 1'b0), 1'b0);
        send_char(qsu_pkg::CH_BSLASH, 1'b0);
        send_char(16'h007A, 1'b0);                 // unknown escape passes the char through
        send_char(qsu_pkg::CH_DQUOTE, 1'b0);
    endtask

    task automatic test_errors();
        send_char(qsu_pkg::CH_DQUOTE, 1'b0);
        send_char(qsu_pkg::CH_BSLASH, 1'b0);
        send_eod();                                // cut off after backslash
        send_char(qsu_pkg::CH_SQUOTE, 1'b0);
        send_char(qsu_pkg::CH_BSLASH, 1'b0);
        send_char(qsu_pkg::CH_U, 1'b0);
        send_char(16'h0047, 1'b0);                 // 'G' is not a hex digit
        send_char(qsu_pkg::CH_DQUOTE, 1'b0);
        send_eod();                                // cut off in the body
    endtask

    task automatic test_random_strings();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            if ($urandom_range(0, 9) == 0)
                src_gap_en = ~src_gap_en;
            if ($urandom_range(0, 9) == 0)
                sink_stall_en = ~sink_stall_en;
            send_random_string();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_framing();
        test_escapes();
        test_errors();
        test_random_strings();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d input transfers in %0d random strings plus directed cases, %0d results",
                 items_sent, strings_sent, results_checked);
        $display("covered plain text, control and unicode escapes, truncation and bad digits");
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
